// ----- sv/ufcw_pkg.sv -----
package ufcw_pkg;

  localparam int NODES_DEF = 1024;
  localparam int IDX_W     = 10;
  localparam int SUM_W     = 32;
  localparam int RANK_W    = 4;
  localparam int RANK_INIT = 1;
  localparam int RANK_MAX  = 15;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_FIND_B,
    ST_LINK,
    ST_ADDW,
    ST_DONE
  } state_t;

  typedef enum logic {
    MODE_UNION = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] root;
  } result_t;

endpackage

// ----- sv/ufcw_mem.sv -----
module ufcw_mem import ufcw_pkg::*; #(
  parameter int NODES = NODES_DEF,
  parameter int DW    = SUM_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(NODES)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(NODES)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [NODES];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/ufcw_alu.sv -----
module ufcw_alu import ufcw_pkg::*; (
  input  logic [SUM_W-1:0] op_x,
  input  logic [SUM_W-1:0] op_y,
  input  logic [RANK_W-1:0] rank_x,
  input  logic [RANK_W-1:0] rank_y,
  output logic [SUM_W-1:0] sum,
  output logic             x_wins,
  output logic [RANK_W-1:0] win_rank
);

  // wrapping sum, shared by the merge and the weight add
  assign sum = op_x + op_y;

  // union by rank; on a tie x stays root and its rank rises, saturating
  assign x_wins = !(rank_x < rank_y);

  always_comb begin
    if (rank_x == rank_y && rank_x < RANK_W'(RANK_MAX)) begin
      win_rank = rank_x + RANK_W'(1);
    end else if (rank_x < rank_y) begin
      win_rank = rank_y;
    end else begin
      win_rank = rank_x;
    end
  end

endmodule

// ----- sv/ufcw_ctrl.sv -----
module ufcw_ctrl import ufcw_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [IDX_W-1:0]         in_first_index,
  input  logic [IDX_W-1:0]         in_second_index,
  input  logic signed [SUM_W-1:0]  in_edge_weight,
  output logic                     mem_we,
  output logic [$clog2(NODES)-1:0] mem_waddr,
  output logic [$clog2(NODES)+RANK_W+SUM_W-1:0] mem_wdata,
  output logic [$clog2(NODES)-1:0] mem_raddr,
  input  logic [$clog2(NODES)+RANK_W+SUM_W-1:0] mem_rdata,
  input  logic                     res_take,
  output logic                     res_valid,
  output result_t                  res
);

  localparam int IW = $clog2(NODES);

  state_t            state_r, state_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     b_r, b_nxt;
  logic [SUM_W-1:0]  w_r, w_nxt;
  logic              mode_r, mode_nxt;
  logic [IW-1:0]     ra_r, ra_nxt;
  logic [IW-1:0]     rb_r, rb_nxt;
  logic [RANK_W-1:0] rka_r, rka_nxt;
  logic [RANK_W-1:0] rkb_r, rkb_nxt;
  logic [SUM_W-1:0]  sa_r, sa_nxt;
  logic [SUM_W-1:0]  sb_r, sb_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [IW-1:0]     win_r, win_nxt;
  logic [RANK_W-1:0] wrank_r, wrank_nxt;
  result_t           res_r, res_nxt;

  logic [IW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic [SUM_W-1:0]  rd_sum;
  logic              a_bad;
  logic              b_bad;

  logic [SUM_W-1:0]  alu_x;
  logic [SUM_W-1:0]  alu_y;
  logic [SUM_W-1:0]  alu_sum;
  logic              alu_x_wins;
  logic [RANK_W-1:0] alu_win_rank;

  ufcw_alu u_alu (
    .op_x     (alu_x),
    .op_y     (alu_y),
    .rank_x   (rka_r),
    .rank_y   (rkb_r),
    .sum      (alu_sum),
    .x_wins   (alu_x_wins),
    .win_rank (alu_win_rank)
  );

  assign rd_parent = mem_rdata[IW+RANK_W+SUM_W-1 -: IW];
  assign rd_rank   = mem_rdata[RANK_W+SUM_W-1 -: RANK_W];
  assign rd_sum    = mem_rdata[SUM_W-1:0];

  assign a_bad = (32'(in_first_index) >= NODES);
  assign b_bad = (32'(in_second_index) >= NODES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    b_r     <= b_nxt;
    w_r     <= w_nxt;
    mode_r  <= mode_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    rka_r   <= rka_nxt;
    rkb_r   <= rkb_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    acc_r   <= acc_nxt;
    win_r   <= win_nxt;
    wrank_r <= wrank_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    mode_nxt  = mode_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    rka_nxt   = rka_r;
    rkb_nxt   = rkb_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    acc_nxt   = acc_r;
    win_nxt   = win_r;
    wrank_nxt = wrank_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = '0;
    mem_raddr = cur_r;
    alu_x     = sa_r;
    alu_y     = w_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {clr_r, RANK_W'(RANK_INIT), {SUM_W{1'b0}}};
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == IW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = IW'(in_first_index);
        if (in_valid) begin
          mode_nxt = in_mode;
          cur_nxt  = IW'(in_first_index);
          b_nxt    = IW'(in_second_index);
          w_nxt    = in_edge_weight;
          // out-of-range items are dropped without a result
          if (!(a_bad || (mode_t'(in_mode) == MODE_UNION && b_bad))) begin
            state_nxt = ST_FIND_A;
          end
        end
      end
      ST_FIND_A: begin
        if (rd_parent == cur_r) begin
          ra_nxt  = cur_r;
          rka_nxt = rd_rank;
          sa_nxt  = rd_sum;
          if (mode_t'(mode_r) == MODE_QUERY) begin
            res_nxt.sum  = rd_sum;
            res_nxt.root = IDX_W'(cur_r);
            state_nxt    = ST_DONE;
          end else begin
            cur_nxt   = b_r;
            mem_raddr = b_r;
            state_nxt = ST_FIND_B;
          end
        end else begin
          cur_nxt   = rd_parent;
          mem_raddr = rd_parent;
        end
      end
      ST_FIND_B: begin
        if (rd_parent == cur_r) begin
          rb_nxt    = cur_r;
          rkb_nxt   = rd_rank;
          sb_nxt    = rd_sum;
          state_nxt = ST_LINK;
        end else begin
          cur_nxt   = rd_parent;
          mem_raddr = rd_parent;
        end
      end
      ST_LINK: begin
        mem_we = 1'b1;
        if (ra_r == rb_r) begin
          alu_x        = sa_r;
          alu_y        = w_r;
          mem_waddr    = ra_r;
          mem_wdata    = {ra_r, rka_r, alu_sum};
          res_nxt.sum  = alu_sum;
          res_nxt.root = IDX_W'(ra_r);
          state_nxt    = ST_DONE;
        end else begin
          alu_x     = sa_r;
          alu_y     = sb_r;
          acc_nxt   = alu_sum;
          wrank_nxt = alu_win_rank;
          if (alu_x_wins) begin
            win_nxt   = ra_r;
            mem_waddr = rb_r;
            mem_wdata = {ra_r, rkb_r, sb_r};
          end else begin
            win_nxt   = rb_r;
            mem_waddr = ra_r;
            mem_wdata = {rb_r, rka_r, sa_r};
          end
          state_nxt = ST_ADDW;
        end
      end
      ST_ADDW: begin
        alu_x        = acc_r;
        alu_y        = w_r;
        mem_we       = 1'b1;
        mem_waddr    = win_r;
        mem_wdata    = {win_r, wrank_r, alu_sum};
        res_nxt.sum  = alu_sum;
        res_nxt.root = IDX_W'(win_r);
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

// ----- sv/union_find_component_weight.sv -----
// disjoint-set table with a weight sum per component
// input channel (in_valid/in_ready): in_mode selects union (0) or query (1);
//   a union links the sets of in_first_index and in_second_index and adds
//   in_edge_weight to the merged sum, a query reads the sum of its set
// result channel (out_valid/out_ready): one item per accepted input item that
//   is not dropped, out_component_sum and out_root_index of the component
// items whose used index is not below NODES are dropped and give no result
// sequence: a query runs ST_FIND_A then ST_DONE; a union runs ST_FIND_A,
//   ST_FIND_B, ST_LINK, ST_ADDW and ST_DONE (no ST_ADDW when both are already
//   in one set); each find takes one hop per tree level walked (at most about
//   log2(NODES) levels), each hop one read of the single node memory port
// one item at a time: in_ready is high only while the sequencer is idle,
//   so no new item is taken before the last result has left the sequencer
// reset: a clearing pass writes every node back to its own root with rank 1
//   and sum 0; in_ready stays low during the pass
// a stalled receiver holds the result in the output register; a following
//   item may be accepted and is held in the sequencer until the slot frees
module union_find_component_weight import ufcw_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic [IDX_W-1:0]        in_first_index,
  input  logic [IDX_W-1:0]        in_second_index,
  input  logic signed [SUM_W-1:0] in_edge_weight,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] out_component_sum,
  output logic [IDX_W-1:0]        out_root_index
);

  localparam int IW = $clog2(NODES);
  localparam int DW = IW + RANK_W + SUM_W;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  logic          res_take;
  logic          res_valid;
  result_t       res;

  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;
  logic [IDX_W-1:0] out_root_r;

  ufcw_mem #(
    .NODES (NODES),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ufcw_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_edge_weight  (in_edge_weight),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .res_take        (res_take),
    .res_valid       (res_valid),
    .res             (res)
  );

  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_sum_r  <= res.sum;
      out_root_r <= res.root;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_component_sum = out_sum_r;
  assign out_root_index    = out_root_r;

endmodule

// ----- sv/ufcw_chk.sv -----
module ufcw_chk import ufcw_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SUM_W-1:0] out_component_sum,
  input logic [IDX_W-1:0]        out_root_index
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_component_sum)
      && $stable(out_root_index))
    else $error("result changed while stalled");

  // clearing pass blocks input right after reset
  a_clear_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a root is always a real node
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_root_index) < NODES))
    else $error("root index out of range");

endmodule

bind union_find_component_weight ufcw_chk #(.NODES(NODES)) u_chk (.*);

// ----- bench/union_find_component_weight_tb.sv -----
`timescale 1ns / 1ps
module union_find_component_weight_tb import ufcw_pkg::*; ();

  localparam int NODES = NODES_DEF;
  localparam int SHOWN_MAX = 10;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = MODE_UNION;
  logic [IDX_W-1:0] in_first_index = '0;
  logic [IDX_W-1:0] in_second_index = '0;
  logic signed [SUM_W-1:0] in_edge_weight = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_component_sum;
  logic [IDX_W-1:0] out_root_index;

  logic [IDX_W-1:0] parent_of [NODES];
  logic [RANK_W-1:0] rank_of [NODES];
  logic [SUM_W-1:0] sum_of [NODES];
  result_t expected_components[$];
  int mismatches = 0;
  bit idle_en = 1'b1;
  int stall_left = 0;
  int fresh_count = 0;

  union_find_component_weight #(
    .NODES(NODES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_first_index(in_first_index),
    .in_second_index(in_second_index),
    .in_edge_weight(in_edge_weight),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_component_sum(out_component_sum),
    .out_root_index(out_root_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [IDX_W-1:0] find_set_root(logic [IDX_W-1:0] node);
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] nxt;
    top = node;
    while (parent_of[top] != top) top = parent_of[top];
    while (node != top) begin
      nxt = parent_of[node];
      parent_of[node] = top;
      node = nxt;
    end
    return top;
  endfunction

  function automatic result_t predict_component(mode_t mode, logic [IDX_W-1:0] a,
                                                logic [IDX_W-1:0] b,
                                                logic [SUM_W-1:0] w);
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] t;
    result_t r;
    ra = find_set_root(a);
    if (mode == MODE_UNION) begin
      rb = find_set_root(b);
      if (ra != rb) begin
        if (rank_of[ra] < rank_of[rb]) begin
          t = ra;
          ra = rb;
          rb = t;
        end
        parent_of[rb] = ra;
        if (rank_of[ra] == rank_of[rb] && rank_of[ra] < RANK_MAX) begin
          rank_of[ra] = rank_of[ra] + 1'b1;
        end
        sum_of[ra] = sum_of[ra] + sum_of[rb];
      end
      sum_of[ra] = sum_of[ra] + w;
    end
    r.sum = sum_of[ra];
    r.root = ra;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] fresh_node();
    logic [IDX_W-1:0] n;
    n = IDX_W'((fresh_count * 389 + 200) % NODES);
    fresh_count++;
    return n;
  endfunction

  function automatic logic [SUM_W-1:0] rand_weight();
    logic [SUM_W-1:0] w;
    case ($urandom_range(0, 3))
      0: w = SUM_W'($signed($urandom_range(0, 200)) - 100);
      1: w = $urandom();
      2: w = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: w = $urandom();
    endcase
    return w;
  endfunction

  function automatic void note_mismatch(string what, result_t want);
    mismatches++;
    if (mismatches <= SHOWN_MAX) begin
      $display("%0t: %s: expected sum %0d root %0d, got sum %0d root %0d", $realtime,
               what, $signed(want.sum), want.root, out_component_sum, out_root_index);
    end
  endfunction

  task automatic send_item(mode_t mode, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                           logic [SUM_W-1:0] w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_first_index <= a;
    in_second_index <= b;
    in_edge_weight <= w;
    expected_components.push_back(predict_component(mode, a, b, w));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_components.size() == 0) begin
        want = '0;
        note_mismatch("result with no item pending", want);
      end else begin
        want = expected_components.pop_front();
        if (out_component_sum !== want.sum || out_root_index !== want.root) begin
          note_mismatch("component mismatch", want);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(MODE_QUERY, 10'd0, 10'd1023, 32'hffff_ffff);
    send_item(MODE_QUERY, 10'd1023, 10'd0, 32'h7fff_ffff);
    send_item(MODE_UNION, 10'd5, 10'd5, 32'h7fff_ffff);
    send_item(MODE_UNION, 10'd5, 10'd5, 32'h0000_0001);
    send_item(MODE_UNION, 10'd0, 10'd1023, 32'h8000_0000);
    send_item(MODE_UNION, 10'd7, 10'd0, 32'hffff_ffff);
    send_item(MODE_UNION, 10'd0, 10'd7, 32'h0000_0000);
    send_item(MODE_QUERY, 10'd1023, 10'd1023, 32'h8000_0000);
    send_item(MODE_UNION, 10'd5, 10'd1023, 32'h0000_0003);
    send_item(MODE_QUERY, 10'd5, 10'h2aa, 32'h5555_aaaa);
    send_item(MODE_UNION, 10'd100, 10'd101, 32'h0000_0010);
    send_item(MODE_UNION, 10'd102, 10'd103, 32'hffff_fff0);
    send_item(MODE_UNION, 10'd101, 10'd103, 32'h0000_0001);
    send_item(MODE_UNION, 10'd103, 10'd7, 32'h8000_0000);
    send_item(MODE_QUERY, 10'd102, 10'h155, 32'haaaa_5555);
    send_item(MODE_QUERY, 10'd512, 10'd511, 32'h0);
  endtask

  // merge fresh nodes pairwise so ranks rise and finds walk deep trees
  task automatic test_binomial_merge();
    logic [IDX_W-1:0] grp [16];
    int step;
    for (int g = 0; g < 8; g++) begin
      for (int i = 0; i < 16; i++) grp[i] = fresh_node();
      for (step = 1; step < 16; step = step * 2) begin
        for (int i = 0; i + step < 16; i += 2 * step) begin
          if ($urandom_range(0, 1)) begin
            send_item(MODE_UNION, grp[i + $urandom_range(0, step - 1)],
                      grp[i + step + $urandom_range(0, step - 1)], rand_weight());
          end else begin
            send_item(MODE_UNION, grp[i + step + $urandom_range(0, step - 1)],
                      grp[i + $urandom_range(0, step - 1)], rand_weight());
          end
        end
      end
      for (int q = 0; q < 5; q++) begin
        send_item(MODE_QUERY, grp[$urandom_range(0, 15)], IDX_W'($urandom()), $urandom());
      end
    end
  endtask

  task automatic test_random_pool(int count, int pool_size);
    logic [IDX_W-1:0] pool [$];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    for (int i = 0; i < pool_size; i++) pool.push_back(fresh_node());
    for (int i = 0; i < count; i++) begin
      a = pool[$urandom_range(0, pool_size - 1)];
      b = pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 9) == 0) a = IDX_W'($urandom());
      if ($urandom_range(0, 9) < 6) begin
        send_item(MODE_UNION, a, b, rand_weight());
      end else begin
        send_item(MODE_QUERY, a, IDX_W'($urandom()), $urandom());
      end
    end
  endtask

  task automatic test_full_range();
    for (int i = 0; i < 100; i++) begin
      send_item($urandom_range(0, 1) ? MODE_QUERY : MODE_UNION, IDX_W'($urandom()),
                IDX_W'($urandom()), $urandom());
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_pool(60, 20);
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) begin
      parent_of[i] = IDX_W'(i);
      rank_of[i] = RANK_W'(RANK_INIT);
      sum_of[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_binomial_merge();
    test_random_pool(300, 40);
    test_full_range();
    test_back_to_back();
    in_valid <= 1'b0;
    while (expected_components.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ufcw_pkg.sv
sv/ufcw_mem.sv
sv/ufcw_alu.sv
sv/ufcw_ctrl.sv
sv/union_find_component_weight.sv
sv/ufcw_chk.sv
bench/union_find_component_weight_tb.sv
